// ----- rtl/core/fpsb_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsb_pkg
// shared types and constants of the binned power spectrum core
// ----------------------------------------------------------------------------
package fpsb_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_ON    = 3'd4;

    localparam logic [19:0]  UNITY_Q16  = 20'h10000;
    localparam logic [29:0]  COUNT_MAX  = 30'h3FFF_FFFF;
    localparam logic [47:0]  KSUM_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0]  PSUM_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [18:0]  MEANK_MAX  = 19'h7FFFF;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ACCUM = 2'd1,
        REQ_READ  = 2'd2,
        REQ_TABLE = 2'd3
    } t_req;

    typedef struct packed {
        t_req               req_type;
        logic [9:0]         index_x;
        logic [9:0]         index_y;
        logic [9:0]         index_z;
        logic signed [23:0] real_part;
        logic signed [23:0] imag_part;
        logic [7:0]         bin_select;
        logic [19:0]        table_entry;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    typedef struct packed {
        logic [10:0] grid_size;
        logic [18:0] bin_origin;
        logic [23:0] inverse_bin_width;
        logic [8:0]  num_bins;
        logic        correction_on;
    } t_cfg;

    // one bin entry: count, k sum, power sum
    typedef struct packed {
        logic [29:0] count;
        logic [47:0] ksum;
        logic [63:0] psum;
    } t_bin;

endpackage

// ----- rtl/core/fourier_power_spectrum_binner_core.sv -----
// ----------------------------------------------------------------------------
// fourier_power_spectrum_binner_core
// binned power spectrum of a half-complex 3d grid with window correction
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   payload
//  command   in         start & !busy               i_req_type .. i_table_entry
//  result    out        o_result_strobe (1 cycle)   o_bin_number .. o_bin_filled
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_wdata
//
//  sequencing: clear and table words finish in the decode state, accumulate
//    words pass through the bit-serial square root, read words through the
//    bit-serial divider for the bin means
//  reset: after reset the window table is filled with unity, and busy
//    stays high until the fill is done
//  stalls: a two-word queue decouples intake from the sequencer; busy rises
//    when the queue is full or during the table fill; the receiver cannot stall results
//
module fourier_power_spectrum_binner_core import fpsb_pkg::*; #(
    parameter int MAX_GRID = 1024,
    parameter int MAX_BINS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_req_type,
    input  logic [9:0]           i_index_x,
    input  logic [9:0]           i_index_y,
    input  logic [9:0]           i_index_z,
    input  logic signed [23:0]   i_real_part,
    input  logic signed [23:0]   i_imag_part,
    input  logic [7:0]           i_bin_select,
    input  logic [19:0]          i_table_entry,
    // result channel
    output logic                 o_result_strobe,
    output logic [7:0]           o_bin_number,
    output logic [18:0]          o_mean_k,
    output logic [63:0]          o_mean_power,
    output logic [29:0]          o_mode_count,
    output logic                 o_bin_filled,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg  r_cfg;
    t_item w_item;
    t_q2b  w_head;
    logic  w_pop, w_init;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size         <= 11'd512;
            r_cfg.bin_origin        <= 19'd0;
            r_cfg.inverse_bin_width <= 24'd65536;
            r_cfg.num_bins          <= 9'd64;
            r_cfg.correction_on     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_SIZE:  r_cfg.grid_size         <= i_cfg_wdata[10:0];
                CFG_BIN_ORIGIN: r_cfg.bin_origin        <= i_cfg_wdata[18:0];
                CFG_INV_WIDTH:  r_cfg.inverse_bin_width <= i_cfg_wdata[23:0];
                CFG_NUM_BINS:   r_cfg.num_bins          <= i_cfg_wdata[8:0];
                CFG_CORR_ON:    r_cfg.correction_on     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pack the command word
    assign w_item.req_type    = t_req'(i_req_type);
    assign w_item.index_x     = i_index_x;
    assign w_item.index_y     = i_index_y;
    assign w_item.index_z     = i_index_z;
    assign w_item.real_part   = i_real_part;
    assign w_item.imag_part   = i_imag_part;
    assign w_item.bin_select  = i_bin_select;
    assign w_item.table_entry = i_table_entry;

    // intake queue
    fpsb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (w_item),
        .i_hold  (w_init),
        .i_pop   (w_pop),
        .o_busy  (busy),
        .o_head  (w_head)
    );

    // sequencer with window table and bin store
    fpsb_back #(
        .MAX_GRID (MAX_GRID),
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_init       (w_init),
        .o_strobe     (o_result_strobe),
        .o_bin_number (o_bin_number),
        .o_mean_k     (o_mean_k),
        .o_mean_power (o_mean_power),
        .o_mode_count (o_mode_count),
        .o_bin_filled (o_bin_filled)
    );

endmodule

// ----- rtl/core/fpsb_front.sv -----
// ----------------------------------------------------------------------------
// fpsb_front
// command intake: two-word queue in front of the execution sequencer
// ----------------------------------------------------------------------------
module fpsb_front import fpsb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_item i_item,
    input  logic  i_hold,
    input  logic  i_pop,
    output logic  o_busy,
    output t_q2b  o_head
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_busy = i_hold || (r_cnt == 2'd2);
    assign w_push = i_start && !o_busy;
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- rtl/core/fpsb_back.sv -----
// ----------------------------------------------------------------------------
// fpsb_back
// execution sequencer: root, binning, window weight, bin update, bin means
// ----------------------------------------------------------------------------
module fpsb_back import fpsb_pkg::*; #(
    parameter int MAX_GRID = 1024,
    parameter int MAX_BINS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_q2b        i_head,
    output logic        o_pop,
    output logic        o_init,
    output logic        o_strobe,
    output logic [7:0]  o_bin_number,
    output logic [18:0] o_mean_k,
    output logic [63:0] o_mean_power,
    output logic [29:0] o_mode_count,
    output logic        o_bin_filled
);

    localparam int TW = $clog2(MAX_GRID);
    localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    typedef enum logic [15:0] {
        S_INIT = 16'h0001,
        S_IDLE = 16'h0002,
        S_DEC  = 16'h0004,
        S_ROOT = 16'h0008,
        S_BIN  = 16'h0010,
        S_CHK  = 16'h0020,
        S_W0   = 16'h0040,
        S_W1   = 16'h0080,
        S_W2   = 16'h0100,
        S_T1   = 16'h0200,
        S_T2   = 16'h0400,
        S_T3   = 16'h0800,
        S_UPD  = 16'h1000,
        S_RDW  = 16'h2000,
        S_DIV  = 16'h4000,
        S_OUT  = 16'h8000
    } t_state;

    t_state        r_state;
    t_item         r_cmd;
    logic [TW-1:0] r_init_addr;
    logic [21:0]   r_k2;
    logic [18:0]   r_root, r_mask, r_bin;
    logic [47:0]   r_pa, r_pb, r_p;
    logic [19:0]   r_tx, r_tq;
    logic [27:0]   r_w;
    logic [43:0]   r_th, r_tl;
    logic [63:0]   r_term;
    t_bin          r_bq;
    logic [MAX_BINS-1:0] r_bval;
    logic [29:0]   r_div;
    logic [30:0]   r_remk, r_remp;
    logic [63:0]   r_qk, r_qp;
    logic [5:0]    r_dcnt;

    logic [19:0]   m_tab [MAX_GRID];
    t_bin          m_bin [MAX_BINS];

    // decode of the command register
    logic [10:0]  w_n, w_half, w_ix, w_iy, w_iz, w_mx, w_my;
    logic         w_grid_ok, w_in_range, w_xneg, w_yneg, w_redundant;
    logic [21:0]  w_k2;
    logic [18:0]  w_t;
    logic [37:0]  w_sq, w_v;
    logic         w_sel_ok, w_bin_ok, w_rd_hit;
    logic signed [47:0] w_re_sq, w_im_sq;
    logic [TW-1:0] w_taddr;
    logic [BW-1:0] w_baddr, w_bidx;
    logic         w_tab_we;
    logic [TW-1:0] w_tab_wa;
    logic [19:0]  w_tab_wd;
    t_bin         w_cur, w_new;
    logic [48:0]  w_ks;
    logic [64:0]  w_ps;
    logic [30:0]  w_rk, w_rp;
    logic         w_gek, w_gep;

    assign w_n      = i_cfg.grid_size;
    assign w_half   = {1'b0, w_n[10:1]};
    assign w_ix     = {1'b0, r_cmd.index_x};
    assign w_iy     = {1'b0, r_cmd.index_y};
    assign w_iz     = {1'b0, r_cmd.index_z};
    assign w_grid_ok  = (w_n >= 11'd2) && (32'(w_n) <= 32'(MAX_GRID));
    assign w_in_range = (w_ix < w_n) && (w_iy < w_n) && (w_iz <= w_half);
    assign w_xneg   = w_ix > w_half;
    assign w_yneg   = w_iy > w_half;
    assign w_mx     = w_xneg ? (w_n - w_ix) : w_ix;
    assign w_my     = w_yneg ? (w_n - w_iy) : w_iy;
    // lower half plane of the z = 0 slab mirrors the upper one
    assign w_redundant = (r_cmd.index_z == 10'd0) &&
        (w_xneg || ((r_cmd.index_x == 10'd0) && (w_yneg || (r_cmd.index_y == 10'd0))));
    assign w_k2 = 22'(22'(w_mx) * 22'(w_mx)) + 22'(22'(w_my) * 22'(w_my))
                + 22'(22'(w_iz) * 22'(w_iz));

    // one root bit per cycle by trial square
    assign w_t  = r_root | r_mask;
    assign w_sq = 38'(w_t) * 38'(w_t);
    assign w_v  = {r_k2, 16'd0};

    assign w_sel_ok = 32'(r_cmd.bin_select) < 32'(MAX_BINS);
    assign w_bin_ok = (r_bin < {10'd0, i_cfg.num_bins}) && (32'(r_bin) < 32'(MAX_BINS));
    assign w_rd_hit = w_sel_ok && r_bval[BW'(r_cmd.bin_select)] && (r_bq.count != 30'd0);
    assign w_re_sq  = r_cmd.real_part * r_cmd.real_part;
    assign w_im_sq  = r_cmd.imag_part * r_cmd.imag_part;
    assign w_bidx   = BW'(r_bin);

    always_comb begin
        case (r_state)
            S_W0:    w_taddr = TW'(r_cmd.index_y);
            S_W1:    w_taddr = TW'(r_cmd.index_z);
            default: w_taddr = TW'(r_cmd.index_x);
        endcase
    end

    assign w_baddr = (r_state == S_DEC) ? BW'(r_cmd.bin_select) : w_bidx;

    always_comb begin
        w_tab_we = 1'b0;
        w_tab_wa = r_init_addr;
        w_tab_wd = UNITY_Q16;
        if (r_state == S_INIT) begin
            w_tab_we = 1'b1;
        end else if (r_state == S_DEC && r_cmd.req_type == REQ_TABLE &&
                     32'(r_cmd.index_x) < 32'(MAX_GRID)) begin
            w_tab_we = 1'b1;
            w_tab_wa = TW'(r_cmd.index_x);
            w_tab_wd = r_cmd.table_entry;
        end
    end

    // saturating bin update
    assign w_cur = r_bval[w_bidx] ? r_bq : '0;
    assign w_ks  = {1'b0, w_cur.ksum} + 49'(r_root);
    assign w_ps  = {1'b0, w_cur.psum} + {1'b0, r_term};
    always_comb begin
        w_new.count = (w_cur.count == COUNT_MAX) ? COUNT_MAX : w_cur.count + 30'd1;
        w_new.ksum  = w_ks[48] ? KSUM_MAX : w_ks[47:0];
        w_new.psum  = w_ps[64] ? PSUM_MAX : w_ps[63:0];
    end

    // restoring division step, k and power side by side
    assign w_rk  = {r_remk[29:0], r_qk[63]};
    assign w_rp  = {r_remp[29:0], r_qp[63]};
    assign w_gek = w_rk >= {1'b0, r_div};
    assign w_gep = w_rp >= {1'b0, r_div};

    assign o_pop  = (r_state == S_IDLE) && i_head.valid;
    assign o_init = (r_state == S_INIT);

    always_ff @(posedge i_clk) begin
        if (w_tab_we) m_tab[w_tab_wa] <= w_tab_wd;
        r_tq <= m_tab[w_taddr];
        if (r_state == S_UPD) m_bin[w_bidx] <= w_new;
        r_bq <= m_bin[w_baddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_bval      <= '0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe <= (r_state == S_OUT) || ((r_state == S_RDW) && !w_rd_hit);
            case (r_state)
                S_INIT: begin
                    r_init_addr <= r_init_addr + 1'b1;
                    if (r_init_addr == TW'(MAX_GRID - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd   <= i_head.item;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    case (r_cmd.req_type)
                        REQ_CLEAR: begin
                            r_bval  <= '0;
                            r_state <= S_IDLE;
                        end
                        REQ_READ:  r_state <= S_RDW;
                        REQ_ACCUM: begin
                            if (w_grid_ok && w_in_range && !w_redundant) begin
                                r_k2    <= w_k2;
                                r_root  <= '0;
                                r_mask  <= 19'h40000;
                                r_state <= S_ROOT;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_ROOT: begin
                    if (w_sq <= w_v) r_root <= w_t;
                    r_mask <= r_mask >> 1;
                    if (r_mask[0]) r_state <= S_BIN;
                end
                S_BIN: begin
                    if (r_root < i_cfg.bin_origin) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_bin <= 19'((43'(r_root - i_cfg.bin_origin) *
                                      43'(i_cfg.inverse_bin_width)) >> 24);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_pa    <= 48'(w_re_sq);
                    r_state <= w_bin_ok ? S_W0 : S_IDLE;
                end
                S_W0: begin
                    r_tx    <= r_tq;
                    r_pb    <= 48'(w_im_sq);
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_w     <= 28'((40'(r_tx) * 40'(r_tq)) >> 16);
                    r_p     <= r_pa + r_pb;
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_w <= i_cfg.correction_on ?
                           28'((44'(r_w[23:0]) * 44'(r_tq)) >> 16) : 28'(UNITY_Q16);
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_th    <= 44'(r_p[47:32]) * 44'(r_w);
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_tl    <= 44'((60'(r_p[31:0]) * 60'(r_w)) >> 16);
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_term  <= (64'(r_th) << 16) + 64'(r_tl);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_bval[w_bidx] <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_RDW: begin
                    if (w_rd_hit) begin
                        r_div   <= r_bq.count;
                        r_qk    <= {16'd0, r_bq.ksum};
                        r_qp    <= r_bq.psum;
                        r_remk  <= '0;
                        r_remp  <= '0;
                        r_dcnt  <= 6'd63;
                        r_state <= S_DIV;
                    end else begin
                        o_bin_number <= r_cmd.bin_select;
                        o_mean_k     <= '0;
                        o_mean_power <= '0;
                        o_mode_count <= '0;
                        o_bin_filled <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_remk <= w_gek ? (w_rk - {1'b0, r_div}) : w_rk;
                    r_remp <= w_gep ? (w_rp - {1'b0, r_div}) : w_rp;
                    r_qk   <= {r_qk[62:0], w_gek};
                    r_qp   <= {r_qp[62:0], w_gep};
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == 6'd0) r_state <= S_OUT;
                end
                S_OUT: begin
                    o_bin_number <= r_cmd.bin_select;
                    o_mean_k     <= (r_qk > 64'(MEANK_MAX)) ? MEANK_MAX : r_qk[18:0];
                    o_mean_power <= r_qp;
                    o_mode_count <= r_div;
                    o_bin_filled <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result strobe held two cycles");
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_OUT || $past(r_state) == S_RDW))
        else $error("result word outside read path");
    a_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_bin_filled == (o_mode_count != 30'd0)))
        else $error("bin_filled disagrees with mode_count");
    a_no_pop_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_pop) else $error("command taken during table fill");

endmodule

// ----- verif/fourier_power_spectrum_binner_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_power_spectrum_binner_core_tb
// self-checking bench for the binned power spectrum core: directed words for
// the folding, skip and drop rules, a saturation run, then several register
// settings each followed by random words; every read result is checked
// against an in-bench bin model
// ----------------------------------------------------------------------------
module fourier_power_spectrum_binner_core_tb;
    import fpsb_pkg::*;

    localparam int GRID_LIM   = 1024;
    localparam int BIN_LIM    = 256;
    localparam int DRAIN_CYC  = 300;      // covers the longest word, queue of two
    localparam int CYCLE_LIM  = 3000000;

    typedef struct {
        logic [7:0]  bin_number;
        logic [18:0] mean_k;
        logic [63:0] mean_power;
        logic [29:0] mode_count;
        logic        bin_filled;
    } t_bin_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_item cmd = '0;
    logic                 o_result_strobe;
    logic [7:0]           o_bin_number;
    logic [18:0]          o_mean_k;
    logic [63:0]          o_mean_power;
    logic [29:0]          o_mode_count;
    logic                 o_bin_filled;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    always #4 i_clk = ~i_clk;

    fourier_power_spectrum_binner_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (cmd.req_type),
        .i_index_x       (cmd.index_x),
        .i_index_y       (cmd.index_y),
        .i_index_z       (cmd.index_z),
        .i_real_part     (cmd.real_part),
        .i_imag_part     (cmd.imag_part),
        .i_bin_select    (cmd.bin_select),
        .i_table_entry   (cmd.table_entry),
        .o_result_strobe (o_result_strobe),
        .o_bin_number    (o_bin_number),
        .o_mean_k        (o_mean_k),
        .o_mean_power    (o_mean_power),
        .o_mode_count    (o_mode_count),
        .o_bin_filled    (o_bin_filled),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // ---------------------------------------------------------------- bin model
    t_cfg        model_cfg;
    logic [19:0] win_table [GRID_LIM];
    logic [29:0] cnt_mem   [BIN_LIM];
    logic [47:0] ksum_mem  [BIN_LIM];
    logic [63:0] psum_mem  [BIN_LIM];

    t_bin_report pending_reports [$];
    int mismatches = 0;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic clear_bin_model();
        for (int b = 0; b < BIN_LIM; b++) begin
            cnt_mem[b] = '0;
            ksum_mem[b] = '0;
            psum_mem[b] = '0;
        end
    endtask

    task automatic accumulate_mode(input t_item it);
        int n, half, ix, iy, iz, fx, fy;
        longint unsigned k2, kq, bin, p, w;
        longint signed re, im;
        logic [127:0] prod;
        logic [63:0] term;
        logic [64:0] psum_next;
        logic [48:0] ksum_next;
        n = model_cfg.grid_size;
        if (n < 2 || n > GRID_LIM) return;
        half = n >> 1;
        ix = it.index_x;
        iy = it.index_y;
        iz = it.index_z;
        if (ix >= n || iy >= n || iz > half) return;
        fx = (ix <= half) ? ix : ix - n;
        fy = (iy <= half) ? iy : iy - n;
        // redundant half of the z = 0 plane, zero mode included
        if (iz == 0 && (fx < 0 || (fx == 0 && fy <= 0))) return;
        k2 = longint'(fx * fx) + longint'(fy * fy) + longint'(iz * iz);
        kq = int_root(k2 << 16);
        if (kq < model_cfg.bin_origin) return;
        bin = ((kq - model_cfg.bin_origin) * model_cfg.inverse_bin_width) >> 24;
        if (bin >= model_cfg.num_bins || bin >= BIN_LIM) return;
        re = it.real_part;
        im = it.imag_part;
        p = re * re + im * im;
        if (model_cfg.correction_on) begin
            w = (longint'(win_table[ix]) * win_table[iy]) >> 16;
            w = (w * win_table[iz]) >> 16;
            prod = 128'(p) * 128'(w);
            term = prod[79:16];
        end else begin
            term = p;
        end
        if (cnt_mem[bin] != COUNT_MAX) cnt_mem[bin]++;
        ksum_next = {1'b0, ksum_mem[bin]} + 49'(kq);
        ksum_mem[bin] = ksum_next[48] ? KSUM_MAX : ksum_next[47:0];
        psum_next = {1'b0, psum_mem[bin]} + {1'b0, term};
        psum_mem[bin] = psum_next[64] ? PSUM_MAX : psum_next[63:0];
    endtask

    // apply one accepted word to the model, queue the read report if any
    task automatic update_bin_model(input t_item it);
        t_bin_report rep;
        longint unsigned mk;
        case (it.req_type)
            REQ_CLEAR: clear_bin_model();
            REQ_ACCUM: accumulate_mode(it);
            REQ_TABLE: win_table[it.index_x] = it.table_entry;
            default: begin
                rep.bin_number = it.bin_select;
                rep.mode_count = cnt_mem[it.bin_select];
                rep.bin_filled = (rep.mode_count != 0);
                rep.mean_k = '0;
                rep.mean_power = '0;
                if (rep.bin_filled) begin
                    mk = ksum_mem[it.bin_select] / rep.mode_count;
                    rep.mean_k = (mk > MEANK_MAX) ? MEANK_MAX : mk[18:0];
                    rep.mean_power = psum_mem[it.bin_select] / rep.mode_count;
                end
                pending_reports.push_back(rep);
            end
        endcase
    endtask

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_bin_report want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: bin %0d", o_bin_number);
            end else begin
                want = pending_reports.pop_front();
                if (o_bin_number !== want.bin_number || o_mean_k !== want.mean_k ||
                    o_mean_power !== want.mean_power ||
                    o_mode_count !== want.mode_count ||
                    o_bin_filled !== want.bin_filled) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch bin %0d/%0d k %0d/%0d pwr %0d/%0d cnt %0d/%0d fill %0b/%0b (exp/act)",
                                 want.bin_number, o_bin_number, want.mean_k, o_mean_k,
                                 want.mean_power, o_mean_power, want.mode_count,
                                 o_mode_count, want.bin_filled, o_bin_filled);
                end
            end
        end
    end

    // run watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIM) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers
    // called at a falling edge, returns at a falling edge
    task automatic send_word(input t_item it);
        cmd = it;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        update_bin_model(it);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return;                               // back to back
        if (r < 93) repeat ($urandom_range(1, 4)) @(negedge i_clk);
        else repeat ($urandom_range(20, 90)) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_GRID_SIZE:  model_cfg.grid_size = val[10:0];
            CFG_BIN_ORIGIN: model_cfg.bin_origin = val[18:0];
            CFG_INV_WIDTH:  model_cfg.inverse_bin_width = val[23:0];
            CFG_NUM_BINS:   model_cfg.num_bins = val[8:0];
            default:        model_cfg.correction_on = val[0];
        endcase
    endtask

    // wait for every report, then let trailing accumulate words retire
    task automatic wait_idle();
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic set_binning(input int unsigned grid, input int unsigned origin,
                               input int unsigned invw, input int unsigned nbins,
                               input int unsigned corr);
        wait_idle();
        write_reg(CFG_GRID_SIZE, grid);
        write_reg(CFG_BIN_ORIGIN, origin);
        write_reg(CFG_INV_WIDTH, invw);
        write_reg(CFG_NUM_BINS, nbins);
        write_reg(CFG_CORR_ON, corr);
    endtask

    function automatic t_item noise_word();
        t_item it;
        it = {$urandom, $urandom, $urandom, $urandom};
        return it;
    endfunction

    function automatic t_item word_of(input t_req kind, input int x, input int y, input int z,
                                      input int re, input int im);
        t_item it;
        it = noise_word();
        it.req_type = kind;
        it.index_x = x;
        it.index_y = y;
        it.index_z = z;
        it.real_part = re;
        it.imag_part = im;
        return it;
    endfunction

    task automatic read_bins(input int first, input int last);
        t_item it;
        for (int b = first; b <= last; b++) begin
            it = noise_word();
            it.req_type = REQ_READ;
            it.bin_select = b;
            send_word(it);
        end
    endtask

    // ---------------------------------------------------------------- tests
    // reset registers: grid 512, unit bin width, 64 bins, no correction
    task automatic test_directed();
        t_item it;
        send_word(word_of(REQ_CLEAR, 0, 0, 0, 0, 0));
        send_word(word_of(REQ_ACCUM, 1, 0, 0, 24'h7FFFFF, 24'h800000));   // bin 1
        send_word(word_of(REQ_ACCUM, 0, 1, 0, 3, -4));                    // fx 0, fy > 0
        send_word(word_of(REQ_ACCUM, 0, 0, 0, 100, 100));                 // zero mode skipped
        send_word(word_of(REQ_ACCUM, 511, 3, 0, 100, 100));               // fx < 0 at z 0
        send_word(word_of(REQ_ACCUM, 0, 511, 0, 5, 5));                   // fy < 0 at z 0
        send_word(word_of(REQ_ACCUM, 511, 511, 1, 7, -7));                // z > 0 kept
        send_word(word_of(REQ_ACCUM, 256, 256, 256, 24'h800000, 0));      // nyquist corner
        send_word(word_of(REQ_ACCUM, 3, 3, 257, 9, 9));                   // z beyond half
        send_word(word_of(REQ_ACCUM, 600, 3, 3, 9, 9));                   // index beyond grid
        send_word(word_of(REQ_ACCUM, 1023, 1023, 1023, 9, 9));
        send_word(word_of(REQ_ACCUM, 40, 40, 40, 1, 1));                  // bin beyond 64
        it = noise_word();
        it.req_type = REQ_TABLE;
        it.index_x = 1023;
        it.table_entry = 20'hFFFFF;
        send_word(it);
        read_bins(0, 2);
        read_bins(69, 69);                                              // beyond num_bins
        read_bins(255, 255);
        send_word(word_of(REQ_CLEAR, 0, 0, 0, 0, 0));
        read_bins(1, 1);
    endtask

    // correction on with a large window pushes the power sum into saturation
    task automatic test_power_saturation();
        t_item it;
        set_binning(8, 0, 65536, 8, 1);
        for (int a = 0; a < 8; a++) begin
            it = noise_word();
            it.req_type = REQ_TABLE;
            it.index_x = a;
            it.table_entry = 20'hFFFFF;
            send_word(it);
        end
        for (int j = 0; j < 40; j++) begin
            send_word(word_of(REQ_ACCUM, 1, 1, 1, 24'h800000, 24'h800000));
            if (j % 8 == 7) read_bins(1, 1);
        end
        read_bins(0, 7);
        it = noise_word();
        it.req_type = REQ_TABLE;
        it.index_x = 0;
        it.table_entry = 20'h00000;
        send_word(it);
        send_word(word_of(REQ_ACCUM, 0, 2, 0, 1000, 1000));
        read_bins(2, 2);
    endtask

    task automatic test_random_mix(input int items, input int small_k);
        t_item it;
        int n, half, r;
        n = model_cfg.grid_size;
        if (n < 2 || n > GRID_LIM) n = 16;
        half = n >> 1;
        for (int j = 0; j < items; j++) begin
            it = noise_word();
            r = $urandom_range(0, 99);
            if (r < 66) begin
                it.req_type = REQ_ACCUM;
                if (small_k && $urandom_range(0, 1)) begin
                    // stay near the origin so small bins fill on a large grid
                    it.index_x = ($urandom_range(0, 1) ? $urandom_range(0, 6)
                                                       : n - $urandom_range(1, 6));
                    it.index_y = ($urandom_range(0, 1) ? $urandom_range(0, 6)
                                                       : n - $urandom_range(1, 6));
                    it.index_z = $urandom_range(0, (half < 6) ? half : 6);
                end else begin
                    it.index_x = $urandom_range(0, n - 1);
                    it.index_y = $urandom_range(0, n - 1);
                    it.index_z = $urandom_range(0, half);
                end
                if ($urandom_range(0, 9) == 0) begin
                    it.real_part = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                    it.imag_part = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                end
            end else if (r < 80) begin
                it.req_type = REQ_READ;
                if ($urandom_range(0, 3) != 0)
                    it.bin_select = $urandom_range(0, model_cfg.num_bins == 0 ? 0 :
                                                      model_cfg.num_bins - 1);
            end else if (r < 89) begin
                it.req_type = REQ_TABLE;
                if ($urandom_range(0, 1)) it.index_x = $urandom_range(0, n - 1);
                if ($urandom_range(0, 1)) it.table_entry = $urandom_range(32768, 131072);
            end else if (r < 91) begin
                it.req_type = REQ_CLEAR;
            end else begin
                it.req_type = REQ_ACCUM;                            // raw indices
            end
            send_word(it);
            sender_gap();
        end
        read_bins(0, 3);
    endtask

    initial begin
        model_cfg = '{grid_size: 11'd512, bin_origin: '0, inverse_bin_width: 24'd65536,
                      num_bins: 9'd64, correction_on: 1'b0};
        for (int a = 0; a < GRID_LIM; a++) win_table[a] = UNITY_Q16;
        clear_bin_model();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_power_saturation();
        set_binning(16, 0, 151552, 32, 1);
        test_random_mix(130, 0);
        set_binning(1024, 256, 4096, 256, 0);
        test_random_mix(110, 1);
        set_binning(1024, 0, 24'hFFFFFF, 256, 1);
        test_random_mix(90, 1);
        set_binning(7, 0, 300000, 12, 1);                        // odd grid
        test_random_mix(90, 0);
        set_binning(2, 19'h7FFFF, 1, 1, 0);                      // highest origin drops all
        test_random_mix(40, 0);
        set_binning(2, 0, 65536, 4, 0);                          // smallest grid
        test_random_mix(50, 0);
        set_binning(0, 0, 65536, 0, 0);                          // bad grid, no bins
        test_random_mix(30, 0);
        set_binning(2047, 0, 65536, 64, 0);
        test_random_mix(20, 0);

        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
